[design/buzzer_note_sequencer_macros.svh]
// Assertion macros for the buzzer note sequencer.
// Used by the top level; no other dependencies.
`ifndef BUZZER_NOTE_SEQUENCER_MACROS_SVH
`define BUZZER_NOTE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define BNS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bns assertion failed");
`define BNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bns assertion failed");
`else
`define BNS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BNS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/bns_pkg.sv]
// Shared types and codes for the buzzer note sequencer.
// No dependencies.
package bns_pkg;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_LOAD    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_TONE = 2'd1;
	localparam logic [1:0] ACT_OFF  = 2'd2;

	localparam logic REG_SONG_LENGTH = 1'b0;
	localparam logic REG_REPEAT_MODE = 1'b1;

	localparam int SONG_LENGTH_W = 9;
	localparam int NOTE_W        = 16;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] level;
		logic [3:0] step;
		logic       done;
	} result_t;

endpackage

[design/buzzer_note_sequencer.sv]
// Buzzer note sequencer top level: control registers, note player, result buffer.
// Depends on bns_pkg, bns_ram and buzzer_note_sequencer_macros.svh.
//
// Takes one request per clock cycle while in_ready is high (tick, song load or
// restart); its result, if any, is registered. The song memory is read every
// cycle at the address of the note that the next tick plays, so a tick finds
// its note word ready and ticks can come back to back; a load to that same
// entry is forwarded. Two results can wait at the output; in_ready drops only
// while both are held. There is no clearing pass after reset: playing a song
// entry that was never loaded gives undefined tone fields.
module buzzer_note_sequencer #(
	parameter int SONG_DEPTH     = 256,
	parameter int OFF_TICK_SCALE = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  load_index,
	input  logic [15:0] note_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  buzzer_action,
	output logic [3:0]  tone_level,
	output logic [3:0]  tone_step,
	output logic        song_done
);

	import bns_pkg::*;
	`include "buzzer_note_sequencer_macros.svh"

	localparam int AW       = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;
	localparam int NIW      = AW + 1;
	localparam int TICK_MAX = 15 + 15 * OFF_TICK_SCALE;
	localparam int TW       = $clog2(TICK_MAX + 1);

	logic [SONG_LENGTH_W-1:0] song_length_q;
	logic                     repeat_mode_q;
	logic                     cfg_wr;

	logic [NIW-1:0] note_index_q, note_index_d;
	logic [TW-1:0]  tick_count_q, tick_count_d;
	logic           stopped_q, stopped_d;

	logic              accept;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	logic [NOTE_W-1:0] mem_rdata;
	logic              fwd_q;
	logic [NOTE_W-1:0] fwd_word_q;
	logic [NOTE_W-1:0] cur_word;

	logic [TW-1:0] on_ticks;
	logic [TW-1:0] off_ticks;
	logic [TW-1:0] note_ticks;
	logic          at_end;

	logic    res_push;
	result_t res_d;
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    pop;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			song_length_q <= '0;
			repeat_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SONG_LENGTH: song_length_q <= pwdata[SONG_LENGTH_W-1:0];
				REG_REPEAT_MODE: repeat_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SONG_LENGTH: prdata = {{(32-SONG_LENGTH_W){1'b0}}, song_length_q};
			REG_REPEAT_MODE: prdata = {31'b0, repeat_mode_q};
			default:         prdata = '0;
		endcase
	end

	// Song memory
	assign accept    = in_valid & in_ready;
	assign mem_we    = accept && (op == OP_LOAD) && (32'(load_index) < SONG_DEPTH);
	assign mem_waddr = AW'(load_index);
	assign mem_raddr = note_index_d[AW-1:0];

	bns_ram #(
		.WIDTH(NOTE_W),
		.DEPTH(SONG_DEPTH)
	) u_song_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(note_word),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= mem_we && (mem_waddr == mem_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_word_q <= note_word;
	end

	assign cur_word = fwd_q ? fwd_word_q : mem_rdata;

	// Note player
	assign on_ticks   = TW'(cur_word[11:8]);
	assign off_ticks  = TW'(32'(cur_word[15:12]) * OFF_TICK_SCALE);
	assign note_ticks = on_ticks + off_ticks;
	assign at_end     = (32'(note_index_q) >= 32'(song_length_q))
		|| (32'(note_index_q) >= SONG_DEPTH);

	always_comb begin
		note_index_d = note_index_q;
		tick_count_d = tick_count_q;
		stopped_d    = stopped_q;
		res_push     = 1'b0;
		res_d        = '{action: ACT_NONE, level: 4'd0, step: 4'd0, done: 1'b0};
		if (accept) begin
			case (op)
				OP_RESTART: begin
					note_index_d = '0;
					tick_count_d = TW'(1);
					stopped_d    = 1'b0;
					res_push     = 1'b1;
					res_d.action = ACT_OFF;
				end
				OP_TICK: begin
					if (!stopped_q) begin
						res_push = 1'b1;
						if (at_end) begin
							res_d.action = ACT_OFF;
							res_d.done   = 1'b1;
							if (repeat_mode_q) begin
								note_index_d = '0;
								tick_count_d = TW'(1);
							end else begin
								stopped_d = 1'b1;
							end
						end else if (tick_count_q < on_ticks) begin
							res_d.action = ACT_TONE;
							res_d.level  = cur_word[7:4];
							res_d.step   = cur_word[3:0];
							tick_count_d = tick_count_q + TW'(1);
						end else if (tick_count_q < note_ticks) begin
							res_d.action = ACT_OFF;
							tick_count_d = tick_count_q + TW'(1);
						end else begin
							note_index_d = note_index_q + NIW'(1);
							tick_count_d = '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_index_q <= '0;
			tick_count_q <= TW'(1);
			stopped_q    <= 1'b0;
		end else begin
			note_index_q <= note_index_d;
			tick_count_q <= tick_count_d;
			stopped_q    <= stopped_d;
		end
	end

	// Result buffer: output register plus one skid entry
	assign pop      = out_valid_q & out_ready;
	assign in_ready = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= res_push;
		end else if (res_push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end else if (!out_valid_q) begin
			out_q <= res_d;
		end else if (res_push) begin
			skid_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign buzzer_action = out_q.action;
	assign tone_level    = out_q.level;
	assign tone_step     = out_q.step;
	assign song_done     = out_q.done;

	`BNS_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`BNS_ASSERT_SAME(a_index_bound, clk, arst_n, 1'b1, 32'(note_index_q) <= SONG_DEPTH)
	`BNS_ASSERT_SAME(a_tick_bound, clk, arst_n, 1'b1, 32'(tick_count_q) <= TICK_MAX)
	`BNS_ASSERT_NEXT(a_restart_state, clk, arst_n, accept && (op == OP_RESTART), note_index_q == '0 && tick_count_q == TW'(1) && !stopped_q && out_valid_q)

endmodule

[design/bns_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[tb/tb_buzzer_note_sequencer.sv]
// Self-checking testbench for buzzer_note_sequencer: drives tick, load, restart and unused
// op requests, predicts each buzzer result and compares it field by field.
// Depends on bns_pkg and the buzzer_note_sequencer RTL.
module tb_buzzer_note_sequencer;
	import bns_pkg::*;

	localparam int SONG_DEPTH     = 256;
	localparam int OFF_SCALE      = 6;
	localparam int HOLD_LEN       = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_SONG_LENGTH = {REG_SONG_LENGTH, 2'b00};
	localparam logic [2:0] ADDR_REPEAT_MODE = {REG_REPEAT_MODE, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_TICK;
	logic [7:0]  load_index = '0;
	logic [15:0] note_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  buzzer_action;
	logic [3:0]  tone_level;
	logic [3:0]  tone_step;
	logic        song_done;

	// predictor state
	logic [15:0] melody [SONG_DEPTH];
	bit          melody_loaded [SONG_DEPTH];
	logic [8:0]  note_pos = '0;
	int          tick_cnt = 1;
	bit          halted = 1'b0;
	logic [8:0]  len_cfg = '0;
	bit          loop_cfg = 1'b0;
	result_t     tone_queue [$];

	int snd_idle = 0;
	int rcv_idle = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	buzzer_note_sequencer #(
		.SONG_DEPTH(SONG_DEPTH),
		.OFF_TICK_SCALE(OFF_SCALE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.load_index(load_index),
		.note_word(note_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.buzzer_action(buzzer_action),
		.tone_level(tone_level),
		.tone_step(tone_step),
		.song_done(song_done)
	);

	always #4 clk = ~clk;

	function automatic int song_end();
		return (len_cfg > SONG_DEPTH) ? SONG_DEPTH : int'(len_cfg);
	endfunction

	function automatic bit predict_tone(input logic [1:0] o, input logic [7:0] ix,
			input logic [15:0] w, output result_t r);
		int on_t;
		int off_t;
		logic [15:0] note;
		r = '0;
		case (o)
			OP_LOAD: begin
				melody[ix] = w;
				melody_loaded[ix] = 1'b1;
				return 1'b0;
			end
			OP_RESTART: begin
				note_pos = '0;
				tick_cnt = 1;
				halted = 1'b0;
				r.action = ACT_OFF;
				return 1'b1;
			end
			OP_TICK: ;
			default: return 1'b0;
		endcase
		if (halted)
			return 1'b0;
		if (note_pos >= song_end()) begin
			r.action = ACT_OFF;
			r.done = 1'b1;
			if (loop_cfg) begin
				note_pos = '0;
				tick_cnt = 1;
			end else begin
				halted = 1'b1;
			end
			return 1'b1;
		end
		note = melody[note_pos[7:0]];
		on_t = note[11:8];
		off_t = note[15:12] * OFF_SCALE;
		if (tick_cnt < on_t) begin
			r.action = ACT_TONE;
			r.level = note[7:4];
			r.step = note[3:0];
			tick_cnt++;
		end else if (tick_cnt < on_t + off_t) begin
			r.action = ACT_OFF;
			tick_cnt++;
		end else begin
			r.action = ACT_NONE;
			note_pos++;
			tick_cnt = 0;
		end
		return 1'b1;
	endfunction

	function automatic logic [15:0] random_note();
		logic [3:0] off;
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		off = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(2, 15)) : 4'($urandom_range(0, 1));
		return {off, 4'($urandom_range(0, 15)), 4'($urandom), 4'($urandom)};
	endfunction

	task automatic send_request(input logic [1:0] req_op, input logic [7:0] req_index,
			input logic [15:0] req_word);
		result_t r;
		logic [1:0] o;
		logic [7:0] ix;
		o = req_op;
		ix = req_index;
		// send a load of the note instead where a tick would play an empty entry
		if (o == OP_TICK && !halted && note_pos < song_end() && !melody_loaded[note_pos[7:0]]) begin
			o = OP_LOAD;
			ix = note_pos[7:0];
		end
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		load_index <= ix;
		note_word <= req_word;
		do @(posedge clk); while (!in_ready);
		if (predict_tone(o, ix, req_word, r))
			tone_queue.push_back(r);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tone_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_SONG_LENGTH)
			len_cfg = data[8:0];
		else
			loop_cfg = data[0];
	endtask

	task automatic test_directed();
		snd_idle = 0;
		rcv_idle = 0;
		write_reg(ADDR_SONG_LENGTH, 32'd0);
		write_reg(ADDR_REPEAT_MODE, 32'd0);
		send_request(OP_TICK, 8'h00, 16'h0000);
		send_request(OP_TICK, 8'hFF, 16'hFFFF);
		send_request(OP_UNUSED, 8'hFF, 16'hFFFF);
		send_request(OP_RESTART, 8'h00, 16'h0000);
		send_request(OP_TICK, 8'h00, 16'h0000);
		send_request(OP_LOAD, 8'hFF, 16'hFFFF);
		send_request(OP_LOAD, 8'h00, 16'h1234);
		send_request(OP_LOAD, 8'h01, 16'h0000);
		settle();
		write_reg(ADDR_SONG_LENGTH, 32'd2);
		write_reg(ADDR_REPEAT_MODE, 32'd1);
		send_request(OP_RESTART, 8'hFF, 16'hFFFF);
		repeat (11) send_request(OP_TICK, 8'h00, 16'h0000);
	endtask

	task automatic test_length_limits();
		snd_idle = 0;
		rcv_idle = 0;
		settle();
		write_reg(ADDR_SONG_LENGTH, 32'd511);
		write_reg(ADDR_REPEAT_MODE, 32'd1);
		for (int i = 0; i < SONG_DEPTH; i++)
			send_request(OP_LOAD, 8'(i), {8'h00, 8'($urandom)});
		send_request(OP_RESTART, 8'($urandom), 16'($urandom));
		repeat (300) send_request(OP_TICK, 8'($urandom), 16'($urandom));
		settle();
		write_reg(ADDR_SONG_LENGTH, 32'd256);
		write_reg(ADDR_REPEAT_MODE, 32'd0);
		send_request(OP_RESTART, 8'($urandom), 16'($urandom));
		repeat (260) send_request(OP_TICK, 8'($urandom), 16'($urandom));
	endtask

	task automatic test_random(input int snd_pct, input int rcv_pct);
		int sent;
		int song_len;
		int burst;
		int sel;
		snd_idle = snd_pct;
		rcv_idle = rcv_pct;
		sent = 0;
		while (sent < 80) begin
			sel = $urandom_range(0, 19);
			song_len = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(8, 16) : $urandom_range(1, 5);
			settle();
			write_reg(ADDR_SONG_LENGTH, 32'(song_len));
			write_reg(ADDR_REPEAT_MODE, 32'($urandom_range(0, 1)));
			for (int i = 0; i < song_len; i++)
				send_request(OP_LOAD, 8'(i), random_note());
			send_request(OP_RESTART, 8'($urandom), 16'($urandom));
			burst = $urandom_range(20, 80);
			repeat (burst) begin
				sel = $urandom_range(0, 99);
				if (sel < 84)
					send_request(OP_TICK, 8'($urandom), 16'($urandom));
				else if (sel < 92)
					send_request(OP_LOAD, 8'($urandom), random_note());
				else if (sel < 97)
					send_request(OP_RESTART, 8'($urandom), 16'($urandom));
				else
					send_request(OP_UNUSED, 8'($urandom), 16'($urandom));
			end
			sent += song_len + 1 + burst;
		end
	endtask

	task automatic test_backpressure();
		snd_idle = 0;
		rcv_idle = 0;
		settle();
		write_reg(ADDR_SONG_LENGTH, 32'd3);
		write_reg(ADDR_REPEAT_MODE, 32'd1);
		for (int i = 0; i < 3; i++)
			send_request(OP_LOAD, 8'(i), random_note());
		send_request(OP_RESTART, 8'h00, 16'h0000);
		hold_req++;
		repeat (40) send_request(OP_TICK, 8'($urandom), 16'($urandom));
		settle();
		repeat (30) send_request(OP_TICK, 8'($urandom), 16'($urandom));
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			if (tone_queue.size() == 0) begin
				$error("unexpected result: buzzer_action %0d song_done %0d",
					buzzer_action, song_done);
				fail_count++;
			end else begin
				want = tone_queue.pop_front();
				if (buzzer_action !== want.action) begin
					$error("buzzer_action expected %0d got %0d", want.action, buzzer_action);
					fail_count++;
				end
				if (tone_level !== want.level) begin
					$error("tone_level expected %0d got %0d", want.level, tone_level);
					fail_count++;
				end
				if (tone_step !== want.step) begin
					$error("tone_step expected %0d got %0d", want.step, tone_step);
					fail_count++;
				end
				if (song_done !== want.done) begin
					$error("song_done expected %0d got %0d", want.done, song_done);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("tb_buzzer_note_sequencer failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_length_limits();
		test_random(28, 56);
		test_random(56, 28);
		test_random(0, 0);
		test_backpressure();
		settle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_buzzer_note_sequencer passed");
		else
			$display("tb_buzzer_note_sequencer failed");
		$finish;
	end

endmodule

[buzzer_note_sequencer.f]
+incdir+design
design/bns_pkg.sv
design/bns_ram.sv
design/buzzer_note_sequencer.sv
tb/tb_buzzer_note_sequencer.sv
